// ===== rtl/core/rfss_pkg.sv =====
// Package for the range flag state store: defaults, field widths, commands and register map.
package rfss_pkg;

  localparam int unsigned DEFAULT_ENTRY_DEPTH = 4096;

  localparam int unsigned FLAG_W   = 8;
  localparam int unsigned START_W  = 12;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [SIZE_W-1:0] REGION_SIZE_RESET = 13'd4096;

  // Register index, taken from the word offset of the APB address.
  localparam logic REG_REGION_SIZE = 1'b0;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_e;

endpackage

// ===== rtl/core/range_flag_state_store_unit.sv =====
// Range flag state store: one flag byte per entry, set, cleared and tested over index ranges.
//
//   Channel   Direction  Handshake                Payload
//   request   in         in_valid_i / in_ready_o  cmd_i, start_index_i, entry_count_i, flag_mask_i
//   result    out        out_valid_o / out_ready_i any_flag_found_o, range_rejected_o
//   config    in         psel/penable/pwrite      paddr, pwdata, prdata (pready tied high)
//
// A set or clear word walks every entry of its range; a check word walks the range at most
// and stops after the first entry that hits the mask. A rejected range goes straight to
// the result, skipping the walk; a zero count or an unused command walks nothing. The pace
// is set by the single read port and single write port of the flag memory, which the sequencer
// walks one entry per cycle with the write-back of entry i overlapping the read of entry i + 1.
// After reset the memory is zeroed by a clearing pass over every entry, during which no
// request word is accepted; configuration writes are taken throughout.
// A finished result sits in the output register while the next request is accepted, so a
// stalled consumer only holds the block once a second result is ready to leave.
module range_flag_state_store_unit
  import rfss_pkg::*;
#(
  parameter int unsigned ENTRY_DEPTH = DEFAULT_ENTRY_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [START_W-1:0]  start_index_i,
  input  logic [COUNT_W-1:0]  entry_count_i,
  input  logic [FLAG_W-1:0]   flag_mask_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                any_flag_found_o,
  output logic                range_rejected_o,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int unsigned AW = $clog2(ENTRY_DEPTH);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(ENTRY_DEPTH - 1);
  // The store depth, as seen by a 13-bit region size.
  localparam logic [SIZE_W-1:0] DEPTH_CAP =
    (ENTRY_DEPTH > 8191) ? {SIZE_W{1'b1}} : SIZE_W'(ENTRY_DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [AW-1:0]       clr_idx_q;
  logic [SIZE_W-1:0]   region_size_q;
  logic [1:0]          cmd_q;
  logic [FLAG_W-1:0]   mask_q;
  logic [COUNT_W-1:0]  rd_idx_q;
  logic [COUNT_W-1:0]  rd_left_q;
  logic                pend_q;
  logic [COUNT_W-1:0]  pend_idx_q;
  logic                found_q;
  logic                rejected_q;
  logic                out_valid_q;
  logic                any_found_q;
  logic                out_rejected_q;

  // Flag memory with one write port and one registered read port.
  logic [FLAG_W-1:0]   flag_mem [ENTRY_DEPTH];
  logic [FLAG_W-1:0]   mem_rdata_q;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_raddr;
  logic [FLAG_W-1:0]   mem_wdata;

  logic [SIZE_W-1:0]   eff_size;
  logic [COUNT_W:0]    range_end;
  logic                reject_in;
  logic                found_now;
  logic                issue;
  logic                run_done;
  logic                cfg_write;

  // The configuration port never stalls.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_REGION_SIZE);
  assign prdata    = (paddr[2] == REG_REGION_SIZE) ?
                     {{(APB_DW-SIZE_W){1'b0}}, region_size_q} : '0;

  // Bounds test on the incoming word: the region is capped at the store depth.
  assign eff_size  = (region_size_q > DEPTH_CAP) ? DEPTH_CAP : region_size_q;
  assign range_end = {2'b00, start_index_i} + {1'b0, entry_count_i};
  assign reject_in = ({1'b0, start_index_i} >= eff_size) ||
                     (range_end > {1'b0, eff_size});

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign any_flag_found_o = any_found_q;
  assign range_rejected_o = out_rejected_q;

  // Read-modify-write pipeline: the entry read in the previous cycle is written back now,
  // while the next entry of the range is read. The two addresses always differ.
  always_comb begin
    found_now = (state_q == ST_RUN) && pend_q && (cmd_q == CMD_CHECK) &&
                ((mem_rdata_q & mask_q) != '0);
    issue     = (state_q == ST_RUN) && (rd_left_q != '0) && !found_now;
    run_done  = (rd_left_q == '0) || found_now;
    mem_re    = issue;
    mem_raddr = AW'(rd_idx_q);
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = '0;
    end else begin
      mem_we    = (state_q == ST_RUN) && pend_q &&
                  ((cmd_q == CMD_SET) || (cmd_q == CMD_CLEAR));
      mem_waddr = AW'(pend_idx_q);
      mem_wdata = (cmd_q == CMD_SET) ? (mem_rdata_q | mask_q) : (mem_rdata_q & ~mask_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      flag_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= flag_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_idx_q      <= '0;
      region_size_q  <= REGION_SIZE_RESET;
      cmd_q          <= '0;
      mask_q         <= '0;
      rd_idx_q       <= '0;
      rd_left_q      <= '0;
      pend_q         <= 1'b0;
      pend_idx_q     <= '0;
      found_q        <= 1'b0;
      rejected_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      any_found_q    <= 1'b0;
      out_rejected_q <= 1'b0;
    end else begin
      if (cfg_write) begin
        region_size_q <= pwdata[SIZE_W-1:0];
      end
      // In the done state the output register is handled below, where a new result may
      // replace the one leaving.
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (clr_idx_q == LAST_ENTRY) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q      <= cmd_i;
            mask_q     <= flag_mask_i;
            rd_idx_q   <= {1'b0, start_index_i};
            found_q    <= 1'b0;
            pend_q     <= 1'b0;
            rejected_q <= reject_in;
            // An unused command walks nothing and reports no hit.
            if ((cmd_i == CMD_SET) || (cmd_i == CMD_CLEAR) || (cmd_i == CMD_CHECK)) begin
              rd_left_q <= entry_count_i;
            end else begin
              rd_left_q <= '0;
            end
            state_q <= reject_in ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          pend_q     <= issue;
          pend_idx_q <= rd_idx_q;
          if (issue) begin
            rd_idx_q  <= rd_idx_q + 1'b1;
            rd_left_q <= rd_left_q - 1'b1;
          end
          if (found_now) begin
            found_q <= 1'b1;
          end
          if (run_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            any_found_q    <= found_q && !rejected_q;
            out_rejected_q <= rejected_q;
            state_q        <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the range flag state store unit.
module testbench;
  import rfss_pkg::*;

  localparam int unsigned STORE_DEPTH = DEFAULT_ENTRY_DEPTH;
  localparam int unsigned HALF_PERIOD = 2;
  localparam int unsigned RESET_CYCLES = 6;
  // How long the consumer refuses results once, so that the block backs up into its input.
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int unsigned SETTLE_CYCLES = 8;

  // The package names only the three live commands; the fourth code must be ignored.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Registers sit on word boundaries, so the register index lands above the byte offset.
  localparam logic [APB_AW-1:0] REGION_SIZE_ADDR = {REG_REGION_SIZE, 2'b00};

  typedef struct packed {
    logic found;
    logic rejected;
  } answer_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] count;
    logic [FLAG_W-1:0]  mask;
  } request_t;

  // Scoreboard: a shadow copy of the flag store, the live region size and the queue of
  // answers still owed by the block.
  class flag_range_tracker;
    logic [FLAG_W-1:0] flag_bytes [STORE_DEPTH];
    logic [SIZE_W-1:0] region_size;
    answer_t           owed_answers[$];
    int unsigned       failures;
    int unsigned       n_set, n_clear, n_check, n_unused, n_hits, n_rejected, n_answers;

    function new();
      foreach (flag_bytes[i]) flag_bytes[i] = '0;
      region_size = REGION_SIZE_RESET;
    endfunction

    // Work out the answer to an accepted request word and bring the shadow store up to date.
    function void note_request(request_t req);
      int unsigned limit, first, span, k;
      answer_t     ans;
      limit = (region_size > STORE_DEPTH) ? STORE_DEPTH : region_size;
      first = req.start;
      span  = req.count;
      ans   = '0;
      case (req.cmd)
        CMD_SET:   n_set++;
        CMD_CLEAR: n_clear++;
        CMD_CHECK: n_check++;
        default:   n_unused++;
      endcase
      if (first >= limit || first + span > limit) begin
        ans.rejected = 1'b1;
        n_rejected++;
      end else if (req.cmd != CMD_UNUSED) begin
        for (k = 0; k < span; k++) begin
          if (req.cmd == CMD_SET) begin
            flag_bytes[first + k] |= req.mask;
          end else if (req.cmd == CMD_CLEAR) begin
            flag_bytes[first + k] &= ~req.mask;
          end else if ((flag_bytes[first + k] & req.mask) != '0) begin
            ans.found = 1'b1;
            n_hits++;
            break;
          end
        end
      end
      owed_answers.push_back(ans);
    endfunction

    function void check_answer(logic found, logic rejected);
      answer_t want;
      n_answers++;
      if (owed_answers.size() == 0) begin
        failures++;
        $error("result word with nothing outstanding: any_flag_found %0b, range_rejected %0b",
               found, rejected);
        return;
      end
      want = owed_answers.pop_front();
      if (found !== want.found) begin
        failures++;
        $error("any_flag_found: expected %0b, got %0b", want.found, found);
      end
      if (rejected !== want.rejected) begin
        failures++;
        $error("range_rejected: expected %0b, got %0b", want.rejected, rejected);
      end
    endfunction

    function int unsigned pending();
      return owed_answers.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         cmd_i = '0;
  logic [START_W-1:0] start_index_i = '0;
  logic [COUNT_W-1:0] entry_count_i = '0;
  logic [FLAG_W-1:0]  flag_mask_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               any_flag_found_o;
  logic               range_rejected_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  flag_range_tracker tracker = new();
  bit                sender_gaps = 1'b1;
  int unsigned       n_region_writes;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  range_flag_state_store_unit #(
    .ENTRY_DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .start_index_i   (start_index_i),
    .entry_count_i   (entry_count_i),
    .flag_mask_i     (flag_mask_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .any_flag_found_o(any_flag_found_o),
    .range_rejected_o(range_rejected_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Both channels are watched at the clock edge. Every stimulus signal changes through a
  // nonblocking assignment, so the values seen here are the ones the block saw at that edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tracker.note_request({cmd_i, start_index_i, entry_count_i, flag_mask_i});
      end
      if (out_valid_o && out_ready_i) begin
        tracker.check_answer(any_flag_found_o, range_rejected_o);
      end
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request word, hold it until the block takes it, then perhaps idle a while.
  // Called right after a rising clk_i, and returns right after a rising clk_i too. Valid is only
  // lowered when a gap follows, so back-to-back words keep it high throughout.
  task automatic issue_request(logic [1:0] cmd, logic [START_W-1:0] start,
                               logic [COUNT_W-1:0] count, logic [FLAG_W-1:0] mask);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    start_index_i <= start;
    entry_count_i <= count;
    flag_mask_i   <= mask;
    do @(posedge clk_i); while (!in_ready_o);
    gap = sender_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every owed answer has come back; the block is then idle,
  // since every request word yields exactly one result.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // Write region_size over the configuration port and read it straight back.
  task automatic write_region_size(logic [SIZE_W-1:0] value);
    logic [APB_DW-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REGION_SIZE_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.region_size = value;
    n_region_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== APB_DW'(value)) begin
      tracker.failures++;
      $error("region_size readback: expected %0d, got %0d", value, readback);
    end
  endtask

  // Random request word for a given usable size. Most words are well formed and clustered
  // near the bottom of the store so that sets, clears and checks keep overlapping; about
  // one in five is noise over the whole field range, which mostly ends up rejected.
  function automatic request_t random_request(int unsigned usable);
    request_t    r;
    int unsigned window, room, cap, pick;
    pick   = $urandom_range(0, 11);
    r.cmd  = (pick == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
    r.mask = $urandom_range(0, 1) ? 8'(1 << $urandom_range(0, 7)) : 8'($urandom_range(0, 255));
    if (usable == 0 || $urandom_range(0, 4) == 0) begin
      r.start = 12'($urandom_range(0, 4095));
      r.count = 13'($urandom_range(0, 8191));
    end else begin
      window  = (usable < 256) ? usable : 256;
      r.start = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, window - 1))
                                           : 12'($urandom_range(0, usable - 1));
      room = usable - r.start;
      pick = $urandom_range(0, 99);
      // Short ranges keep the run quick; a few words may walk right to the end of the region.
      cap = (pick < 80) ? 16 : (pick < 95) ? 96 : room;
      if (cap > room) cap = room;
      r.count = 13'($urandom_range(0, cap));
    end
    return r;
  endfunction

  // Consumer side: ready in runs of random length with short or long refusals between them.
  // Once forty results have come back it refuses for a long stretch while the producer keeps
  // offering, so the output register and then the input fill up.
  initial begin
    int unsigned run, gap;
    bit          held;
    held = 1'b0;
    repeat (RESET_CYCLES + 1) @(posedge clk_i);
    forever begin
      out_ready_i <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      repeat (run) @(posedge clk_i);
      if (!held && tracker.n_answers >= 40) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    request_t    req;
    int unsigned p, n, len, usable;
    logic [SIZE_W-1:0] region;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset region size of 4096. The block first runs its clearing
    // pass, so the first word also shows that the store comes up empty.
    issue_request(CMD_CHECK, 12'd0, 13'd4096, 8'hFF);    // whole store, nothing found
    issue_request(CMD_SET, 12'd0, 13'd4096, 8'h01);      // whole store, bit 0
    issue_request(CMD_CHECK, 12'd4095, 13'd1, 8'h01);    // last entry alone
    issue_request(CMD_CLEAR, 12'd1, 13'd4095, 8'h01);    // all but entry 0
    issue_request(CMD_CHECK, 12'd1, 13'd4095, 8'h01);    // full walk with no hit
    issue_request(CMD_CHECK, 12'd0, 13'd4096, 8'h01);    // hit on the very first entry
    issue_request(CMD_SET, 12'd4095, 13'd1, 8'h80);
    issue_request(CMD_CHECK, 12'd2048, 13'd2048, 8'h80); // hit on the very last entry
    issue_request(CMD_CHECK, 12'd4095, 13'd2, 8'h80);    // range end one past the region
    issue_request(CMD_SET, 12'd100, 13'd0, 8'hFF);       // zero count changes nothing
    issue_request(CMD_CHECK, 12'd4095, 13'd0, 8'h80);    // zero count finds nothing
    issue_request(CMD_UNUSED, 12'd4095, 13'd1, 8'hFF);   // unused command, range in bounds
    issue_request(CMD_UNUSED, 12'd4095, 13'd2, 8'hFF);   // unused command, range out of bounds
    issue_request(CMD_CHECK, 12'd0, 13'd8191, 8'hFF);    // largest count the field holds
    issue_request(CMD_SET, 12'd10, 13'd5, 8'h00);        // empty mask
    issue_request(CMD_CHECK, 12'd0, 13'd4096, 8'h00);
    issue_request(CMD_CLEAR, 12'd0, 13'd4096, 8'hFF);
    issue_request(CMD_CHECK, 12'd0, 13'd4096, 8'hFF);
    drain_results();

    // Smallest useful region: a single entry.
    write_region_size(13'd1);
    issue_request(CMD_SET, 12'd0, 13'd1, 8'h5A);
    issue_request(CMD_CHECK, 12'd0, 13'd1, 8'h02);
    issue_request(CMD_CHECK, 12'd0, 13'd2, 8'hFF);       // runs past the single entry
    issue_request(CMD_CHECK, 12'd1, 13'd0, 8'hFF);       // start outside, even with no count
    drain_results();

    // A zero region rejects everything.
    write_region_size(13'd0);
    issue_request(CMD_SET, 12'd0, 13'd0, 8'hFF);
    drain_results();

    // Anything above the store depth is treated as the full store.
    write_region_size(13'd8191);
    issue_request(CMD_CHECK, 12'd4095, 13'd1, 8'hFF);
    issue_request(CMD_SET, 12'd0, 13'd4097, 8'hFF);      // one past the saturated size
    drain_results();

    // Random phases, each with its own region size. The producer idles in some phases and
    // streams without a break in others.
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       begin region = 13'd64;   len = 40; end
        1:       begin region = 13'd4096; len = 25; end
        2:       begin region = 13'($urandom_range(2, 300)); len = 25; end
        3:       begin region = 13'd8191; len = 12; end
        4:       begin region = 13'd0;    len = 3;  end
        default: begin region = 13'd4096; len = 10; end
      endcase
      write_region_size(region);
      usable = (region > STORE_DEPTH) ? STORE_DEPTH : region;
      sender_gaps = (p % 2 == 0);
      for (n = 0; n < len; n++) begin
        req = random_request(usable);
        issue_request(req.cmd, req.start, req.count, req.mask);
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d request words: %0d set, %0d clear, %0d check (%0d hits), %0d unused",
             tracker.n_set + tracker.n_clear + tracker.n_check + tracker.n_unused,
             tracker.n_set, tracker.n_clear, tracker.n_check, tracker.n_hits, tracker.n_unused);
    $display("%0d ranges rejected; region_size written %0d times, from 0 up to 8191",
             tracker.n_rejected, n_region_writes);
    if (tracker.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest legitimate run, even if every
  // word walked the whole store behind the longest stalls.
  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
